/* hw/rtl/lmfc_pkg.sv */
// ----------------------------------------------------------------------------
// LED matrix frame controller package
// Shared item types, command codes and register word constants.
// ----------------------------------------------------------------------------
package lmfc_pkg;

    // Host command codes as they arrive on the input channel.
    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_CLR   = 3'd1;
    localparam logic [2:0] CMD_FLUSH = 3'd2;
    localparam logic [2:0] CMD_INIT  = 3'd3;
    localparam logic [2:0] CMD_RAW   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] CFG_SCAN_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_DECODE_MODE = 2'd2;

    // Configuration reset values.
    localparam logic [3:0] BRIGHTNESS_RESET  = 4'd3;
    localparam logic [2:0] SCAN_LIMIT_RESET  = 3'd7;
    localparam logic [7:0] DECODE_MODE_RESET = 8'd0;

    // Device register addresses and fixed data used by the set-up sequence.
    localparam logic [3:0] ADDR_DECODE    = 4'h9;
    localparam logic [3:0] ADDR_INTENSITY = 4'hA;
    localparam logic [3:0] ADDR_SCAN      = 4'hB;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'hC;
    localparam logic [3:0] ADDR_TEST      = 4'hF;
    localparam logic [7:0] DATA_NORMAL    = 8'h01;
    localparam logic [7:0] DATA_TEST_OFF  = 8'h00;

    // Raw row addresses that reach the display.
    localparam logic [7:0] RAW_ADDR_MIN = 8'd1;
    localparam logic [7:0] RAW_ADDR_MAX = 8'd8;

    // Word index of the final word of each run.
    localparam logic [2:0] INIT_LAST_IDX  = 3'd4;
    localparam logic [2:0] FLUSH_LAST_IDX = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic       chain;
        logic [2:0] pixel_x;
        logic [2:0] pixel_y;
        logic [7:0] row_address;
        logic [7:0] row_data;
    } t_in_item;

    typedef struct packed {
        logic       target_chain;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] brightness;
        logic [2:0] scan_limit;
        logic [7:0] decode_mode;
    } t_cfg;

    // Operation kinds that travel from the front end to the back end.
    typedef enum logic [2:0] {
        OP_SET   = 3'd0,
        OP_CLR   = 3'd1,
        OP_FLUSH = 3'd2,
        OP_INIT  = 3'd3,
        OP_RAW   = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic       chain;
        logic [2:0] pixel_x;
        logic [2:0] pixel_y;
        logic [3:0] addr;
        logic [7:0] data;
    } t_op;

endpackage

/* hw/rtl/led_matrix_frame_controller.sv */
// ----------------------------------------------------------------------------
// LED matrix frame controller
// Frame buffer for an 8x8 one-bit matrix that turns host requests into
// device register words for one of two display chains.
// ----------------------------------------------------------------------------
// Usage. Requests enter through a queue-like port: a request is taken at a
// clock edge where i_push is high and o_full is low. Register words leave the
// same way: while o_empty is low the oldest word sits on o_item and is taken
// when i_pop is high. The configuration port (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data) is always ready and should be written only while
// the block has nothing in flight.
// A request passes through the front-end register and the operation queue
// to the back end. Pixel requests update the frame buffer as the back end
// takes them and produce no word. A flush emits eight words, init five and
// a raw row one, one word per cycle while the output register is free or
// popped; the word sequencer sets the throughput. The front end keeps
// taking requests while the operation queue has room.
// Reset clears the frame buffer, the queue and the output register, and
// restores the default configuration. When the receiver stops popping, the
// output register holds its word, the sequencer halts, the queue fills and
// o_full rises.
// ----------------------------------------------------------------------------
module led_matrix_frame_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  lmfc_pkg::t_in_item  i_item,
    output logic                o_empty,
    input  logic                i_pop,
    output lmfc_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import lmfc_pkg::*;

    t_cfg r_cfg;
    logic front_valid;
    t_op  front_op;
    logic queue_ready;
    logic queue_valid;
    t_op  queue_op;
    logic back_pop;

    // Configuration is accepted every cycle; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness  <= BRIGHTNESS_RESET;
            r_cfg.scan_limit  <= SCAN_LIMIT_RESET;
            r_cfg.decode_mode <= DECODE_MODE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS:  r_cfg.brightness  <= i_cfg_data[3:0];
                CFG_SCAN_LIMIT:  r_cfg.scan_limit  <= i_cfg_data[2:0];
                CFG_DECODE_MODE: r_cfg.decode_mode <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end decodes requests and filters out those with no effect.
    lmfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_item     (i_item),
        .o_op_valid (front_valid),
        .o_op       (front_op),
        .i_op_ready (queue_ready)
    );

    // The queue lets the front end keep taking requests during a long flush.
    lmfc_op_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (queue_ready),
        .i_wr_data  (front_op),
        .o_rd_valid (queue_valid),
        .i_rd_en    (back_pop),
        .o_rd_data  (queue_op)
    );

    // The back end owns the frame buffer so pixel updates stay in order
    // with the flushes around them.
    lmfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (queue_valid),
        .o_op_pop   (back_pop),
        .i_op       (queue_op),
        .i_cfg      (r_cfg),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_item     (o_item)
    );

endmodule

/* hw/rtl/lmfc_front.sv */
// ----------------------------------------------------------------------------
// LED matrix frame controller front end
// Accepts host requests, drops the ones that produce nothing, and hands the
// rest to the operation queue as decoded operations.
// ----------------------------------------------------------------------------
module lmfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  lmfc_pkg::t_in_item i_item,
    output logic              o_op_valid,
    output lmfc_pkg::t_op     o_op,
    input  logic              i_op_ready
);
    import lmfc_pkg::*;

    logic r_valid;
    t_op  r_op;
    logic keep;
    t_op  dec;

    always_comb begin
        dec.chain   = i_item.chain;
        dec.pixel_x = i_item.pixel_x;
        dec.pixel_y = i_item.pixel_y;
        dec.addr    = i_item.row_address[3:0];
        dec.data    = i_item.row_data;
        dec.kind    = OP_SET;
        keep        = 1'b1;
        case (i_item.cmd)
            CMD_SET:   dec.kind = OP_SET;
            CMD_CLR:   dec.kind = OP_CLR;
            CMD_FLUSH: dec.kind = OP_FLUSH;
            CMD_INIT:  dec.kind = OP_INIT;
            CMD_RAW: begin
                dec.kind = OP_RAW;
                // Only digit registers one through eight are reachable.
                keep = (i_item.row_address >= RAW_ADDR_MIN) &&
                       (i_item.row_address <= RAW_ADDR_MAX);
            end
            default:   keep = 1'b0;
        endcase
    end

    assign o_full     = r_valid && !i_op_ready;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && !o_full) begin
            r_valid <= keep;
        end else if (i_op_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_op <= dec;
        end
    end

endmodule

/* hw/rtl/lmfc_op_queue.sv */
// ----------------------------------------------------------------------------
// LED matrix frame controller operation queue
// Small first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module lmfc_op_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  lmfc_pkg::t_op i_wr_data,
    output logic          o_rd_valid,
    input  logic          i_rd_en,
    output lmfc_pkg::t_op o_rd_data
);
    import lmfc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op            r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_en && o_rd_valid;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/lmfc_back.sv */
// ----------------------------------------------------------------------------
// LED matrix frame controller back end
// Holds the frame buffer, carries out queued operations and emits register
// words into an output register, one per cycle while it is free or popped.
// ----------------------------------------------------------------------------
module lmfc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    output logic               o_op_pop,
    input  lmfc_pkg::t_op      i_op,
    input  lmfc_pkg::t_cfg     i_cfg,
    output logic               o_empty,
    input  logic               i_pop,
    output lmfc_pkg::t_out_item o_item
);
    import lmfc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state    r_state;
    t_op       r_op;
    logic [2:0] r_cnt;
    logic [7:0] r_fb [8];
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item word;
    logic [7:0] col_bits;
    logic      emit_ok;

    assign emit_ok  = !r_out_valid || i_pop;
    assign o_op_pop = (r_state == ST_IDLE) && i_op_valid;
    assign o_empty  = !r_out_valid;
    assign o_item   = r_out;

    // Column r_cnt of the buffer: bit i comes from row i.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            col_bits[i] = r_fb[i][r_cnt];
        end
    end

    always_comb begin
        word.target_chain = r_op.chain;
        word.reg_address  = '0;
        word.reg_data     = '0;
        word.last         = 1'b0;
        case (r_op.kind)
            OP_FLUSH: begin
                word.reg_address = 4'(r_cnt) + 4'd1;
                word.reg_data    = col_bits;
                word.last        = (r_cnt == FLUSH_LAST_IDX);
            end
            OP_INIT: begin
                word.last = (r_cnt == INIT_LAST_IDX);
                case (r_cnt)
                    3'd0: begin
                        word.reg_address = ADDR_DECODE;
                        word.reg_data    = i_cfg.decode_mode;
                    end
                    3'd1: begin
                        word.reg_address = ADDR_INTENSITY;
                        word.reg_data    = 8'(i_cfg.brightness);
                    end
                    3'd2: begin
                        word.reg_address = ADDR_SCAN;
                        word.reg_data    = 8'(i_cfg.scan_limit);
                    end
                    3'd3: begin
                        word.reg_address = ADDR_SHUTDOWN;
                        word.reg_data    = DATA_NORMAL;
                    end
                    default: begin
                        word.reg_address = ADDR_TEST;
                        word.reg_data    = DATA_TEST_OFF;
                    end
                endcase
            end
            OP_RAW: begin
                word.reg_address = r_op.addr;
                word.reg_data    = r_op.data;
                word.last        = 1'b1;
            end
            default: begin
                word.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            for (int i = 0; i < 8; i++) begin
                r_fb[i] <= '0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_op_valid) begin
                        if (i_op.kind == OP_SET) begin
                            r_fb[i_op.pixel_y][3'(3'd7 - i_op.pixel_x)] <= 1'b1;
                        end else if (i_op.kind == OP_CLR) begin
                            r_fb[i_op.pixel_y][3'(3'd7 - i_op.pixel_x)] <= 1'b0;
                        end else begin
                            r_state <= ST_EMIT;
                            r_cnt   <= '0;
                        end
                    end
                    if (i_pop) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (emit_ok) begin
                        r_out_valid <= 1'b1;
                        r_cnt       <= r_cnt + 1'b1;
                        if (word.last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_op <= i_op;
        end
        if (r_state == ST_EMIT && emit_ok) begin
            r_out <= word;
        end
    end

endmodule
